/* design/chbd_pkg.sv */
// Shared types, constants and byte classifier for the chunked body decoder.
`default_nettype none
package chbd_pkg;

    localparam int unsigned SIZE_BITS_DEF   = 32;
    localparam int unsigned QUEUE_DEPTH     = 4;
    localparam int unsigned QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam logic [31:0] MAX_BODY_RESET  = 32'd1048576;
    localparam logic [31:0] TOTAL_MAX       = 32'hFFFF_FFFF;

    localparam logic [7:0]  CHAR_SEMI       = 8'h3B;
    localparam logic [7:0]  CHAR_CR         = 8'h0D;
    localparam logic [7:0]  CHAR_LF         = 8'h0A;

    localparam logic [1:0]  ST_BUSY         = 2'd0;
    localparam logic [1:0]  ST_DONE         = 2'd1;
    localparam logic [1:0]  ST_BAD          = 2'd2;
    localparam logic [1:0]  ST_BIG          = 2'd3;

    localparam int unsigned APB_ADDR_W      = 3;
    localparam logic [APB_ADDR_W-1:0] REG_MAX_BODY = 3'd0;

    // Classified input byte handed from the front end to the back end
    typedef struct packed {
        logic [7:0] raw;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_semi;
        logic       is_cr;
        logic       is_lf;
    } item_t;

    typedef enum logic [7:0] {
        PH_SIZE    = 8'b0000_0001,
        PH_EXT     = 8'b0000_0010,
        PH_SIZE_LF = 8'b0000_0100,
        PH_DATA    = 8'b0000_1000,
        PH_DATA_CR = 8'b0001_0000,
        PH_DATA_LF = 8'b0010_0000,
        PH_LAST_CR = 8'b0100_0000,
        PH_LAST_LF = 8'b1000_0000
    } phase_t;

    function automatic item_t classify(input logic [7:0] c);
        item_t it;
        it.raw     = c;
        it.is_hex  = 1'b0;
        it.hex_val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            it.is_hex  = 1'b1;
            it.hex_val = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            // letters a-f and A-F share the low three bits
            it.is_hex  = 1'b1;
            it.hex_val = 4'd9 + {1'b0, c[2:0]};
        end
        it.is_semi = (c == CHAR_SEMI);
        it.is_cr   = (c == CHAR_CR);
        it.is_lf   = (c == CHAR_LF);
        return it;
    endfunction

endpackage
`default_nettype wire

/* design/http_chunked_body_decoder_core.sv */
// Path: each accepted byte passes the front register, the queue and then the result register.
// Throughput: one byte per cycle while out_ready stays high; front register, four-entry queue
// and result register absorb short stalls on either side without stopping the other.
// Reset (rst_n, asynchronous, active low): decoder restarts at the size line,
// totals clear, queue empties, max_body_bytes returns to 1048576.
`default_nettype none
module http_chunked_body_decoder_core
#(
    parameter int unsigned SIZE_BITS = chbd_pkg::SIZE_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       data_byte,
    output logic             data_valid,
    output logic [1:0]       status,
    output logic [31:0]      body_length,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import chbd_pkg::*;

    logic [31:0] max_body_reg;
    logic [31:0] max_body_next;
    logic        push_valid;
    logic        push_ready;
    item_t       push_item;
    logic        pop_valid;
    logic        pop_ready;
    item_t       pop_item;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_MAX_BODY) ? max_body_reg : 32'd0;

    always_comb
    begin
        max_body_next = max_body_reg;
        if (psel && penable && pwrite && paddr == REG_MAX_BODY)
        begin
            max_body_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_body_reg <= MAX_BODY_RESET;
        end
        else
        begin
            max_body_reg <= max_body_next;
        end
    end

    chbd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    chbd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    chbd_back
    #(
        .SIZE_BITS (SIZE_BITS)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_body    (max_body_reg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_item    (pop_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_byte   (data_byte),
        .data_valid  (data_valid),
        .status      (status),
        .body_length (body_length)
    );

endmodule
`default_nettype wire

/* design/chbd_front.sv */
// Front end: accepts raw bytes, classifies them and registers the result.
`default_nettype none
module chbd_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      in_byte,
    output logic                 push_valid,
    input  wire logic            push_ready,
    output chbd_pkg::item_t      push_item
);
    import chbd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= classify(in_byte);
        end
    end

endmodule
`default_nettype wire

/* design/chbd_queue.sv */
// Short queue of classified bytes between the front and back ends.
`default_nettype none
module chbd_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire chbd_pkg::item_t push_item,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output chbd_pkg::item_t      pop_item
);
    import chbd_pkg::*;

    item_t                  slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

/* design/chbd_back.sv */
// Back end: chunk framing state machine, length tracking and result register.
`default_nettype none
module chbd_back
#(
    parameter int unsigned SIZE_BITS = chbd_pkg::SIZE_BITS_DEF
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [31:0]     max_body,
    input  wire logic            pop_valid,
    output logic                 pop_ready,
    input  wire chbd_pkg::item_t pop_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [7:0]           data_byte,
    output logic                 data_valid,
    output logic [1:0]           status,
    output logic [31:0]          body_length
);
    import chbd_pkg::*;

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [SIZE_BITS-1:0] chunk_reg;
    logic [SIZE_BITS-1:0] chunk_next;
    logic [SIZE_BITS-1:0] chunk_dec;
    logic                 digit_seen_reg;
    logic                 digit_seen_next;
    logic                 ext_cr_reg;
    logic                 ext_cr_next;
    logic [31:0]          total_reg;
    logic [31:0]          total_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           data_byte_reg;
    logic [7:0]           data_byte_next;
    logic                 data_valid_reg;
    logic                 data_valid_next;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;
    logic [31:0]          body_length_reg;

    logic                 take;

    assign pop_ready   = !out_valid_reg || out_ready;
    assign take        = pop_valid && pop_ready;
    assign out_valid   = out_valid_reg;
    assign data_byte   = data_byte_reg;
    assign data_valid  = data_valid_reg;
    assign status      = status_reg;
    assign body_length = body_length_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        chunk_next      = chunk_reg;
        digit_seen_next = digit_seen_reg;
        ext_cr_next     = ext_cr_reg;
        total_next      = total_reg;
        status_next     = ST_BUSY;
        data_byte_next  = 8'd0;
        data_valid_next = 1'b0;
        chunk_dec       = (chunk_reg != '0) ? chunk_reg - SIZE_BITS'(1) : chunk_reg;

        case (phase_reg)
            PH_SIZE:
            begin
                if (pop_item.is_hex)
                begin
                    // size would spill past SIZE_BITS on this digit
                    if (chunk_reg[SIZE_BITS-1 -: 4] != 4'd0)
                    begin
                        status_next = ST_BIG;
                    end
                    else
                    begin
                        chunk_next      = {chunk_reg[SIZE_BITS-5:0], pop_item.hex_val};
                        digit_seen_next = 1'b1;
                    end
                end
                else if (pop_item.is_semi && digit_seen_reg)
                begin
                    ext_cr_next = 1'b0;
                    phase_next  = PH_EXT;
                end
                else if (pop_item.is_cr && digit_seen_reg)
                begin
                    phase_next = PH_SIZE_LF;
                end
                else
                begin
                    status_next = ST_BAD;
                end
            end
            PH_EXT:
            begin
                if (ext_cr_reg && pop_item.is_lf)
                begin
                    ext_cr_next     = 1'b0;
                    digit_seen_next = 1'b0;
                    phase_next      = (chunk_reg == '0) ? PH_LAST_CR : PH_DATA;
                end
                else
                begin
                    ext_cr_next = pop_item.is_cr;
                end
            end
            PH_SIZE_LF:
            begin
                if (pop_item.is_lf)
                begin
                    ext_cr_next     = 1'b0;
                    digit_seen_next = 1'b0;
                    phase_next      = (chunk_reg == '0) ? PH_LAST_CR : PH_DATA;
                end
                else
                begin
                    status_next = ST_BAD;
                end
            end
            PH_DATA:
            begin
                data_byte_next  = pop_item.raw;
                data_valid_next = 1'b1;
                // total + 1 > max is total >= max; the saturated total is caught too
                if (max_body != 32'd0 && total_reg >= max_body)
                begin
                    status_next = ST_BIG;
                end
                if (total_reg != TOTAL_MAX)
                begin
                    total_next = total_reg + 32'd1;
                end
                chunk_next = chunk_dec;
                if (chunk_dec == '0)
                begin
                    phase_next = PH_DATA_CR;
                end
            end
            PH_DATA_CR:
            begin
                if (pop_item.is_cr)
                begin
                    phase_next = PH_DATA_LF;
                end
                else
                begin
                    status_next = ST_BAD;
                end
            end
            PH_DATA_LF:
            begin
                if (pop_item.is_lf)
                begin
                    phase_next      = PH_SIZE;
                    chunk_next      = '0;
                    digit_seen_next = 1'b0;
                end
                else
                begin
                    status_next = ST_BAD;
                end
            end
            PH_LAST_CR:
            begin
                if (pop_item.is_cr)
                begin
                    phase_next = PH_LAST_LF;
                end
                else
                begin
                    status_next = ST_BAD;
                end
            end
            default:
            begin
                status_next = pop_item.is_lf ? ST_DONE : ST_BAD;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (pop_ready)
        begin
            out_valid_next = pop_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SIZE;
            chunk_reg      <= '0;
            digit_seen_reg <= 1'b0;
            ext_cr_reg     <= 1'b0;
            total_reg      <= 32'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                // restart after any final status
                if (status_next != ST_BUSY)
                begin
                    phase_reg      <= PH_SIZE;
                    chunk_reg      <= '0;
                    digit_seen_reg <= 1'b0;
                    ext_cr_reg     <= 1'b0;
                    total_reg      <= 32'd0;
                end
                else
                begin
                    phase_reg      <= phase_next;
                    chunk_reg      <= chunk_next;
                    digit_seen_reg <= digit_seen_next;
                    ext_cr_reg     <= ext_cr_next;
                    total_reg      <= total_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_byte_reg   <= data_byte_next;
            data_valid_reg  <= data_valid_next;
            status_reg      <= status_next;
            body_length_reg <= total_next;
        end
    end

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the chunked transfer body decoder core.
`timescale 1ns / 1ps
module tb_top;
    import chbd_pkg::*;

    localparam int SZB = SIZE_BITS_DEF;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        data_valid;
        logic [1:0]  status;
        logic [31:0] body_length;
    } body_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic [1:0]  status;
    logic [31:0] body_length;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Decoder state as the testbench sees it
    phase_t          ph;
    logic [SZB-1:0]  remaining;
    logic            digit_seen;
    logic            ext_cr;
    logic [31:0]     total;
    logic [31:0]     body_limit;

    body_result_t results_due[$];
    int unsigned  err_count = 0;
    int unsigned  bytes_sent = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    int unsigned  hold_left = 0;

    http_chunked_body_decoder_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_byte   (data_byte),
        .data_valid  (data_valid),
        .status      (status),
        .body_length (body_length),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    function automatic void restart_decoder();
        ph         = PH_SIZE;
        remaining  = '0;
        digit_seen = 1'b0;
        ext_cr     = 1'b0;
        total      = 32'd0;
    endfunction

    function automatic void close_size_line();
        ext_cr     = 1'b0;
        digit_seen = 1'b0;
        ph         = (remaining == '0) ? PH_LAST_CR : PH_DATA;
    endfunction

    // Advance the decoder by one raw byte and return the beat it must produce
    function automatic body_result_t decode_byte(input logic [7:0] c);
        body_result_t r;
        logic         is_hex;
        logic [3:0]   nib;
        r = '0;
        r.status = ST_BUSY;
        is_hex = 1'b1;
        if (c >= "0" && c <= "9")
            nib = 4'(c - "0");
        else if (c >= "a" && c <= "f")
            nib = 4'(c - "a" + 10);
        else if (c >= "A" && c <= "F")
            nib = 4'(c - "A" + 10);
        else
        begin
            is_hex = 1'b0;
            nib = 4'd0;
        end
        case (ph)
            PH_SIZE:
            begin
                if (is_hex)
                begin
                    if (remaining[SZB-1 -: 4] != 4'd0)
                        r.status = ST_BIG;
                    else
                    begin
                        remaining  = {remaining[SZB-5:0], nib};
                        digit_seen = 1'b1;
                    end
                end
                else if (c == CHAR_SEMI && digit_seen)
                begin
                    ext_cr = 1'b0;
                    ph = PH_EXT;
                end
                else if (c == CHAR_CR && digit_seen)
                    ph = PH_SIZE_LF;
                else
                    r.status = ST_BAD;
            end
            PH_EXT:
            begin
                if (ext_cr && c == CHAR_LF)
                    close_size_line();
                else
                    ext_cr = (c == CHAR_CR);
            end
            PH_SIZE_LF:
            begin
                if (c == CHAR_LF)
                    close_size_line();
                else
                    r.status = ST_BAD;
            end
            PH_DATA:
            begin
                r.data_byte  = c;
                r.data_valid = 1'b1;
                if (body_limit != 32'd0 &&
                    (total == TOTAL_MAX || {1'b0, total} + 33'd1 > {1'b0, body_limit}))
                    r.status = ST_BIG;
                if (total != TOTAL_MAX)
                    total = total + 32'd1;
                if (remaining != '0)
                    remaining = remaining - 1'b1;
                if (remaining == '0)
                    ph = PH_DATA_CR;
            end
            PH_DATA_CR:
            begin
                if (c == CHAR_CR)
                    ph = PH_DATA_LF;
                else
                    r.status = ST_BAD;
            end
            PH_DATA_LF:
            begin
                if (c == CHAR_LF)
                begin
                    ph = PH_SIZE;
                    remaining = '0;
                    digit_seen = 1'b0;
                end
                else
                    r.status = ST_BAD;
            end
            PH_LAST_CR:
            begin
                if (c == CHAR_CR)
                    ph = PH_LAST_LF;
                else
                    r.status = ST_BAD;
            end
            default:
                r.status = (c == CHAR_LF) ? ST_DONE : ST_BAD;
        endcase
        r.body_length = total;
        if (r.status != ST_BUSY)
            restart_decoder();
        return r;
    endfunction

    // Offer one byte, hold it until accepted, then book its expected beat
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        results_due.insert(results_due.size(), decode_byte(b));
        bytes_sent++;
    endtask

    // Hold-off counter for the receiver
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin : rx_side
        body_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (results_due.size() == 0)
                report_mismatch("unexpected beat", {30'd0, status}, 32'd0);
            else
            begin
                want = results_due.pop_front();
                if (data_byte !== want.data_byte)
                    report_mismatch("data_byte", 32'(data_byte), 32'(want.data_byte));
                if (data_valid !== want.data_valid)
                    report_mismatch("data_valid", 32'(data_valid), 32'(want.data_valid));
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (body_length !== want.body_length)
                    report_mismatch("body_length", body_length, want.body_length);
            end
        end
        out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_MAX_BODY;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        if (pready !== 1'b1)
            report_mismatch("pready", 32'(pready), 32'd1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write the body limit while idle and read it back
    task automatic set_body_limit(input logic [31:0] value);
        logic [31:0] rd;
        wait_idle();
        apb_xfer(1'b1, value, rd);
        body_limit = value;
        @(posedge clk);
        apb_xfer(1'b0, 32'd0, rd);
        if (rd !== value)
            report_mismatch("max_body_bytes readback", rd, value);
    endtask

    task automatic set_idling(input int unsigned snd, input int unsigned rcv);
        send_idle_pct = snd;
        recv_idle_pct = rcv;
    endtask

    task automatic push_size_line(ref logic [7:0] q[$], input int unsigned sz);
        int n;
        int i;
        int unsigned v;
        n = 1;
        while (n < 8 && (sz >> (4 * n)) != 0)
            n++;
        repeat ($urandom_range(2)) q.insert(q.size(), "0");
        for (i = n - 1; i >= 0; i--)
        begin
            v = (sz >> (4 * i)) & 15;
            if (v < 10)
                q.insert(q.size(), 8'("0" + v));
            else
                q.insert(q.size(), 8'(($urandom_range(1) ? "A" : "a") + v - 10));
        end
        if ($urandom_range(3) == 0)
        begin
            // extension bytes; a lone CR stays inside it
            q.insert(q.size(), CHAR_SEMI);
            repeat ($urandom_range(5))
                q.insert(q.size(),
                         $urandom_range(4) == 0 ? CHAR_CR : 8'($urandom_range(126, 32)));
        end
        q.insert(q.size(), CHAR_CR);
        q.insert(q.size(), CHAR_LF);
    endtask

    // Build one chunked body, sometimes damaged, and send it
    task automatic send_body(input int unsigned max_chunk);
        logic [7:0]  q[$];
        int unsigned sz;
        int unsigned p;
        q = {};
        repeat ($urandom_range(3))
        begin
            sz = ($urandom_range(9) == 0) ? $urandom_range(300, 1)
                                          : $urandom_range(max_chunk, 1);
            push_size_line(q, sz);
            repeat (sz) q.insert(q.size(), 8'($urandom_range(255)));
            q.insert(q.size(), CHAR_CR);
            q.insert(q.size(), CHAR_LF);
        end
        push_size_line(q, 0);
        q.insert(q.size(), CHAR_CR);
        q.insert(q.size(), CHAR_LF);
        if ($urandom_range(99) < 20)
        begin
            p = $urandom_range(q.size() - 1);
            case ($urandom_range(3))
                0: q[p] = 8'($urandom_range(255));
                1: q.delete(p);
                2: q.insert(p, 8'($urandom_range(255)));
                default: repeat (8) q.push_front("f");
            endcase
        end
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(3, 1)) q.insert(q.size(), 8'($urandom_range(255)));
        foreach (q[i])
            send_byte(q[i]);
    endtask

    task automatic test_special_cases();
        set_idling(35, 71);
        send_byte(CHAR_SEMI);             // empty size
        send_byte(CHAR_CR);               // empty size ended by CR
        send_byte(8'h00);                 // bad size character
        send_byte("1");
        send_byte(CHAR_SEMI);
        send_byte(CHAR_CR);               // lone CR inside the extension
        send_byte("A");
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_byte(8'hFF);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_byte("0");
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);               // body complete
        send_byte("f");
        send_byte("F");
        send_byte(CHAR_CR);
        send_byte("X");                   // CR not followed by LF
        repeat (8) send_byte(CHAR_CR == 8'h00 ? "0" : "1");
        send_byte("0");                   // ninth digit overflows the size
        send_byte("0");
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_byte("X");                   // zero chunk without CRLF
    endtask

    task automatic test_limit_one();
        set_body_limit(32'd1);
        send_byte("1");
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_byte("Z");
        send_byte("Q");                   // payload without CRLF
        send_byte("2");
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_byte("x");
        send_byte("y");                   // second payload byte passes the limit
        send_body(4);
    endtask

    task automatic test_random_bodies(input logic [31:0] limit, input int unsigned snd,
                                      input int unsigned rcv, input int unsigned count);
        int unsigned target;
        set_body_limit(limit);
        set_idling(snd, rcv);
        target = bytes_sent + count;
        while (bytes_sent < target)
            send_body(16);
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        hold_left <= 64;
        send_body(30);
        send_body(30);
    endtask

    initial
    begin
        body_limit = MAX_BODY_RESET;
        restart_decoder();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        test_random_bodies(MAX_BODY_RESET, 35, 71, 250);
        test_limit_one();
        test_random_bodies(32'hFFFF_FFFF, 35, 71, 300);
        test_random_bodies(32'd0, 71, 35, 500);
        test_random_bodies(32'($urandom_range(200, 20)), 0, 0, 500);
        test_backpressure();

        wait_idle();
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
